// ===== design/lsh_pkg.sv =====
// Shared constants, types and register codes of the Laplacian sharpening filter.
package lsh_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int LANES = 4;
  localparam int LANE_W = 8;
  localparam int PIX_W = LANES * LANE_W;
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W = 2;
  localparam int CHAN_W = 3;
  localparam int CLAMP_W = (COL_W + 2 > CFG_DATA_W + 1) ? COL_W + 2 : CFG_DATA_W + 1;
  localparam int OUT_BITS = ROW_W + COL_W + PIX_W + 1;
  localparam int OUT_TDATA_W = ((ROW_W + COL_W + PIX_W + 7) / 8) * 8;
  localparam int OUT_PAD_W = OUT_TDATA_W - (ROW_W + COL_W + PIX_W);
  localparam int IN_TDATA_W = ((PIX_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH = 12'd640;
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_HEIGHT = 12'd480;
  localparam logic [CHAN_W-1:0] RST_CHANNEL_COUNT = 3'd4;

  localparam logic [ROW_W-1:0] MAX_ROW_LAST = 12'd4094;

  typedef logic [LANES-1:0][LANE_W-1:0] pix_t;

  typedef struct packed {
    pix_t prev;
    pix_t prev2;
  } line_word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    pix_t sharp;
    logic done;
  } result_t;

endpackage

// ===== design/lsh_line_buf.sv =====
// Line store holding the two previous rows of the frame, one packed word per column.
module lsh_line_buf
  import lsh_pkg::*;
(
  input  logic             clk,
  input  logic             rd_en,
  input  logic [COL_W-1:0] rd_addr,
  output line_word_t       rd_data,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_addr,
  input  line_word_t       wr_data
);

  line_word_t mem [MAX_WIDTH];
  line_word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/lsh_kernel.sv =====
// Five-point Laplacian sharpening kernel across all channel lanes, saturated to 0..255.
module lsh_kernel
  import lsh_pkg::*;
(
  input  pix_t             centre,
  input  pix_t             left,
  input  pix_t             right,
  input  pix_t             up,
  input  pix_t             down,
  input  logic [LANES-1:0] lane_en,
  input  logic             interior,
  output pix_t             sharp
);

  localparam int SUM_W = LANE_W + 4;

  always_comb begin
    logic signed [SUM_W-1:0] pos;
    logic signed [SUM_W-1:0] neg;
    logic signed [SUM_W-1:0] diff;
    for (int k = 0; k < LANES; k++) begin
      pos = SUM_W'({centre[k], 2'b00}) + SUM_W'(centre[k]);
      neg = SUM_W'(left[k]) + SUM_W'(right[k]) + SUM_W'(up[k]) + SUM_W'(down[k]);
      diff = pos - neg;
      if (!interior || !lane_en[k] || diff < 0) begin
        sharp[k] = '0;
      end else if (diff > SUM_W'({LANE_W{1'b1}})) begin
        sharp[k] = {LANE_W{1'b1}};
      end else begin
        sharp[k] = diff[LANE_W-1:0];
      end
    end
  end

endmodule

// ===== design/laplacian_sharpen_3x3.sv =====
// Top level of the 3x3 Laplacian sharpening filter: counters, pipeline and result sequencing.
//
//   channel | direction | handshake                | payload
//   in_     | sink      | in_tvalid / in_tready    | in_tdata: four 8-bit channel samples
//   out_    | source    | out_tvalid / out_tready  | out_tdata: row, column, four results;
//           |           |                          | out_tlast: last result of the frame
//   cfg_    | sink      | cfg_valid / cfg_ready    | cfg_index, cfg_data: register write
//
// A pixel beat is accepted in any cycle in which the output side keeps pace; the pixel
// waits in the line-store stage, then moves into the result register once that frees
// up, and its first result beat leaves from there. Pixels of the first row yield no
// result beat, most others yield one, the last pixel of a row yields two, and pixels of
// the last row yield up to three, so those pixels hold the input while the result
// register drains. The line store is read once and written once per cycle, which sets
// the one-pixel-per-cycle peak. Reset (rst_n low, synchronous) empties the pipeline,
// zeroes the row and column counters and loads the default frame size of 640 x 480 with
// four channels. A stalled output holds its beat; the input stalls only once both the
// line-store stage and the result register are full.
module laplacian_sharpen_3x3
  import lsh_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // Pixel input. in_tdata, lowest bit up: sample_0, sample_1, sample_2, sample_3.
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Results. out_tdata, lowest bit up: out_row, out_col, sharp_0, sharp_1, sharp_2,
  // sharp_3, zero padding. out_tlast carries frame_done.
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // Register writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers and their clamped forms.
  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;
  logic [CHAN_W-1:0]     chan_r;
  logic [COL_W-1:0]      col_last;
  logic [ROW_W-1:0]      row_last;
  logic [LANES-1:0]      lane_en;

  // Position counters of the next input pixel.
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W-1:0] col_cur;

  // Line-store stage: the pixel waits here for its read of the two rows above.
  logic             s1_valid_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  pix_t             s1_pix_r;
  line_word_t       above_word;

  // Window of the current row pass: column c-1 of the top, middle and bottom rows
  // and column c-2 of the middle row.
  pix_t win_up_r;
  pix_t win_left_r;
  pix_t win_ctr_r;
  pix_t win_down_r;

  // Result register: up to three result beats from one pixel.
  result_t    grp_r [3];
  logic [1:0] grp_cnt_r;
  logic [1:0] grp_idx_r;

  logic    in_acc;
  logic    s1_adv;
  logic    grp_busy;
  logic    grp_last;
  logic    grp_free;
  pix_t    in_pix;
  pix_t    sharp;
  result_t res_int;
  result_t res_edge;
  result_t res_final;
  logic    has_int;
  logic    has_edge;
  logic    has_final;
  result_t grp_nxt [3];
  logic [1:0] grp_cnt_nxt;
  result_t out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      chan_r   <= RST_CHANNEL_COUNT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   width_r  <= cfg_data;
        REG_IMAGE_HEIGHT:  height_r <= cfg_data;
        REG_CHANNEL_COUNT: chan_r   <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range sizes are clamped; a channel count of zero means one lane.
  always_comb begin
    logic [CLAMP_W-1:0] w_ext;
    logic [CLAMP_W-1:0] h_ext;
    logic [CHAN_W-1:0]  chan_eff;
    w_ext = CLAMP_W'(width_r);
    h_ext = CLAMP_W'(height_r);
    if (w_ext < CLAMP_W'(3)) begin
      w_ext = CLAMP_W'(3);
    end else if (w_ext > CLAMP_W'(MAX_WIDTH)) begin
      w_ext = CLAMP_W'(MAX_WIDTH);
    end
    if (h_ext < CLAMP_W'(3)) begin
      h_ext = CLAMP_W'(3);
    end
    col_last = COL_W'(w_ext - CLAMP_W'(1));
    row_last = ROW_W'(h_ext - CLAMP_W'(1));
    if (row_last > MAX_ROW_LAST) begin
      row_last = MAX_ROW_LAST;
    end
    if (chan_r == '0) begin
      chan_eff = CHAN_W'(1);
    end else if (32'(chan_r) > LANES) begin
      chan_eff = CHAN_W'(LANES);
    end else begin
      chan_eff = chan_r;
    end
    for (int k = 0; k < LANES; k++) begin
      lane_en[k] = 32'(chan_eff) > k;
    end
  end

  // Handshake. The result register frees up when it is empty or its last beat leaves.
  assign grp_busy  = grp_cnt_r != 2'd0;
  assign grp_last  = grp_idx_r == (grp_cnt_r - 2'd1);
  assign grp_free  = !grp_busy || (out_tready && grp_last);
  assign s1_adv    = s1_valid_r && grp_free;
  assign in_tready = !s1_valid_r || grp_free;
  assign in_acc    = in_tvalid && in_tready;

  // Counters past a shrunken frame are taken as its last column or row.
  assign row_cur = (row_r > row_last) ? row_last : row_r;
  assign col_cur = (col_r > col_last) ? col_last : col_r;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      in_pix[k] = lane_en[k] ? in_tdata[k*LANE_W +: LANE_W] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (in_acc) begin
      if (col_cur >= col_last) begin
        col_r <= '0;
        row_r <= (row_cur >= row_last) ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_r <= col_cur + COL_W'(1);
        row_r <= row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_row_r <= row_cur;
      s1_col_r <= col_cur;
      s1_pix_r <= in_pix;
    end
  end

  // Consecutive pixels always sit in different columns, so the write of the pixel
  // leaving the line-store stage never meets the read of the pixel entering it.
  lsh_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (col_cur),
    .rd_data (above_word),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data ('{prev: s1_pix_r, prev2: above_word.prev})
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_up_r   <= above_word.prev2;
      win_left_r <= win_ctr_r;
      win_ctr_r  <= above_word.prev;
      win_down_r <= s1_pix_r;
    end
  end

  // The result lags the input by one row and one column: centre is (r-1, c-1).
  lsh_kernel u_kernel (
    .centre   (win_ctr_r),
    .left     (win_left_r),
    .right    (above_word.prev),
    .up       (win_up_r),
    .down     (win_down_r),
    .lane_en  (lane_en),
    .interior ((s1_row_r >= ROW_W'(2)) && (s1_col_r >= COL_W'(2))),
    .sharp    (sharp)
  );

  // Results of one pixel, in order: the lagging interior pixel, the zero right-hand
  // border pixel at the end of a row, and the zero bottom-row pixel in the last row.
  always_comb begin
    has_int   = (s1_row_r != '0) && (s1_col_r != '0);
    has_edge  = has_int && (s1_col_r == col_last);
    has_final = (s1_row_r != '0) && (s1_row_r == row_last);

    res_int.row   = s1_row_r - ROW_W'(1);
    res_int.col   = s1_col_r - COL_W'(1);
    res_int.sharp = sharp;
    res_int.done  = 1'b0;

    res_edge.row   = s1_row_r - ROW_W'(1);
    res_edge.col   = col_last;
    res_edge.sharp = '0;
    res_edge.done  = 1'b0;

    res_final.row   = row_last;
    res_final.col   = s1_col_r;
    res_final.sharp = '0;
    res_final.done  = s1_col_r == col_last;

    grp_nxt[0] = has_int ? res_int : res_final;
    grp_nxt[1] = has_edge ? res_edge : res_final;
    grp_nxt[2] = res_final;
    grp_cnt_nxt = 2'(has_int) + 2'(has_edge) + 2'(has_final);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_cnt_r <= '0;
      grp_idx_r <= '0;
    end else if (s1_adv) begin
      grp_cnt_r <= grp_cnt_nxt;
      grp_idx_r <= '0;
    end else if (grp_busy && out_tready) begin
      if (grp_last) begin
        grp_cnt_r <= '0;
        grp_idx_r <= '0;
      end else begin
        grp_idx_r <= grp_idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      grp_r <= grp_nxt;
    end
  end

  always_comb begin
    unique case (grp_idx_r)
      2'd0:    out_res = grp_r[0];
      2'd1:    out_res = grp_r[1];
      default: out_res = grp_r[2];
    endcase
  end

  assign out_tvalid = grp_busy;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_res.sharp, out_res.col, out_res.row};
  assign out_tlast  = out_res.done;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the 3x3 Laplacian sharpening filter.
`timescale 1ns / 1ps

module tb;
  import lsh_pkg::*;

  // Cycles to let pass after the last expected result before a register write
  // or the end of the run. A pixel beat passes the line-store stage and the
  // result register before its first result, so this leaves a wide margin.
  localparam int SETTLE_CYCLES = 16;

  // Cycles without any accepted beat before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 2000;

  // Percentage of cycles in which either side idles.
  localparam int IDLE_PERCENT = 17;

  // Random stimulus volume, counted in pixel beats.
  localparam int RANDOM_PIXELS = 16;

  // The register map has three entries; index 3 is unmapped.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef enum int {
    STYLE_UNIFORM,
    STYLE_EXTREME,
    STYLE_SMOOTH
  } pixel_style_e;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_tdata, lowest bit up: out_row, out_col, sharp_0, sharp_1, sharp_2,
  // sharp_3, zero padding.
  logic [OUT_TDATA_W-1:0] out_tdata;
  // out_tlast carries frame_done.
  logic                   out_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  laplacian_sharpen_3x3 uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state. It mirrors the two stored rows, the 3x2 window, the
  // position counters and the three registers of the block.
  // ---------------------------------------------------------------------------
  pix_t             line_above [MAX_WIDTH];
  pix_t             line_above2 [MAX_WIDTH];
  pix_t             win_px [6];
  int               next_row = 0;
  int               next_col = 0;
  logic [11:0]      cfg_width = RST_IMAGE_WIDTH;
  logic [11:0]      cfg_height = RST_IMAGE_HEIGHT;
  logic [CHAN_W-1:0] cfg_lanes = RST_CHANNEL_COUNT;

  // Results still owed by the block, oldest first.
  result_t pending_results[$];

  int  err_count = 0;
  int  pixels_sent = 0;
  int  stall_cycles = 0;
  // While set, neither side idles. Used for one long stretch of the run.
  bit  no_idle = 1'b0;

  task automatic report_error(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  task automatic push_result(input int row, input int col, input pix_t px, input bit done);
    result_t r;
    r.row = row[ROW_W-1:0];
    r.col = col[COL_W-1:0];
    r.sharp = px;
    r.done = done;
    pending_results.push_back(r);
  endtask

  // Works out the results caused by one accepted pixel and advances the
  // predictor state exactly as the block does.
  task automatic predict_sharpen(input pix_t px_in);
    int   w, h, nch, r, c, k, s;
    pix_t px, above, above2, val;
    w = int'(cfg_width);
    h = int'(cfg_height);
    nch = int'(cfg_lanes);
    // Out-of-range registers are clamped; zero lanes means one lane.
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 3) h = 3;
    if (h > 4095) h = 4095;
    if (nch < 1) nch = 1;
    if (nch > LANES) nch = LANES;
    // A counter left beyond a freshly shrunk frame acts as the last position.
    r = (next_row > h - 1) ? h - 1 : next_row;
    c = (next_col > w - 1) ? w - 1 : next_col;

    // Inactive lanes are stored as zero.
    px = '0;
    for (k = 0; k < nch; k++) px[k] = px_in[k];
    above = line_above[c];
    above2 = line_above2[c];
    val = '0;

    if (r >= 1) begin
      if (c >= 1) begin
        // Interior pixels only; the first row and column stay zero.
        if (r >= 2 && c >= 2) begin
          for (k = 0; k < nch; k++) begin
            s = 5 * int'(win_px[3][k]) - int'(win_px[2][k]) - int'(above[k])
              - int'(win_px[1][k]) - int'(win_px[5][k]);
            if (s < 0) s = 0;
            if (s > 255) s = 255;
            val[k] = s[7:0];
          end
        end
        push_result(r - 1, c - 1, val, 1'b0);
        // The right border pixel of the row above comes out with the last column.
        if (c == w - 1) push_result(r - 1, w - 1, '0, 1'b0);
      end
      // The bottom border row is emitted alongside the row above it.
      if (r == h - 1) push_result(h - 1, c, '0, c == w - 1);
    end

    win_px[0] = win_px[1];
    win_px[1] = above2;
    win_px[2] = win_px[3];
    win_px[3] = above;
    win_px[4] = win_px[5];
    win_px[5] = px;
    line_above2[c] = above;
    line_above[c] = px;

    if (c >= w - 1) begin
      next_col = 0;
      next_row = (r >= h - 1) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
  endtask

  function automatic bit idle_roll();
    return !no_idle && ($urandom_range(0, 99) < IDLE_PERCENT);
  endfunction

  function automatic pix_t make_pixel(input pixel_style_e style, input int base);
    pix_t p;
    int   k, v, sel;
    for (k = 0; k < LANES; k++) begin
      case (style)
        STYLE_EXTREME: begin
          // Rails half the time, so that both ends of the saturation are hit often.
          sel = $urandom_range(0, 3);
          if (sel == 0) p[k] = 8'd0;
          else if (sel == 1) p[k] = 8'd255;
          else p[k] = 8'($urandom_range(0, 255));
        end
        STYLE_SMOOTH: begin
          // Small ripples around a base give sharpened values that mostly stay clear of saturation.
          v = base + $urandom_range(0, 16) - 8;
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          p[k] = v[7:0];
        end
        default: p[k] = 8'($urandom_range(0, 255));
      endcase
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat-level drivers. Inputs change on the falling edge; handshakes are
  // sampled on the rising edge.
  // ---------------------------------------------------------------------------

  // Sends one pixel beat. in_tvalid stays high after the beat so that
  // back-to-back pixels stream without a gap unless the idle roll says so.
  task automatic send_pixel(input pix_t px);
    @(negedge clk);
    while (idle_roll()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    do @(posedge clk); while (!in_tready);
    predict_sharpen(px);
    pixels_sent++;
  endtask

  // Stops the pixel stream and waits until the block has drained every
  // outstanding result, plus a margin for work that causes no result.
  task automatic drain_block();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes are only issued while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_IMAGE_WIDTH: cfg_width = value[11:0];
      REG_IMAGE_HEIGHT: cfg_height = value[11:0];
      REG_CHANNEL_COUNT: cfg_lanes = value[CHAN_W-1:0];
      default: ;  // Writes to an unmapped index change nothing.
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_frame(input int width, input int height, input int lanes);
    write_reg(REG_IMAGE_WIDTH, width);
    write_reg(REG_IMAGE_HEIGHT, height);
    write_reg(REG_CHANNEL_COUNT, lanes);
  endtask

  // Streams pixels until the frame wraps back to its first position. At least
  // one pixel is always sent, so from the start of a frame this is a full frame.
  task automatic finish_frame(input pixel_style_e style);
    int base;
    base = $urandom_range(8, 247);
    do send_pixel(make_pixel(style, base)); while (!(next_row == 0 && next_col == 0));
  endtask

  // ---------------------------------------------------------------------------
  // Result checker. Every accepted result beat is compared field by field
  // with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin : check_results
    result_t want;
    int      k;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result beat row %0d col %0d with nothing predicted",
                               out_tdata[ROW_W-1:0], out_tdata[ROW_W +: COL_W]));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[ROW_W-1:0] !== want.row)
          report_error($sformatf("out_row got %0d want %0d",
                                 out_tdata[ROW_W-1:0], want.row));
        if (out_tdata[ROW_W +: COL_W] !== want.col)
          report_error($sformatf("out_col got %0d want %0d",
                                 out_tdata[ROW_W +: COL_W], want.col));
        for (k = 0; k < LANES; k++) begin
          if (out_tdata[ROW_W + COL_W + k * LANE_W +: LANE_W] !== want.sharp[k])
            report_error($sformatf("sharp_%0d at (%0d,%0d) got %0d want %0d", k,
                                   want.row, want.col,
                                   out_tdata[ROW_W + COL_W + k * LANE_W +: LANE_W],
                                   want.sharp[k]));
        end
        if (out_tlast !== want.done)
          report_error($sformatf("frame_done at (%0d,%0d) got %b want %b",
                                 want.row, want.col, out_tlast, want.done));
      end
    end
  end

  // Watchdog: ends the run if no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[laplacian_sharpen_3x3] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Sends a dozen pixels into the first row at the reset frame size of
  // 640 x 480 with four lanes; a narrower reset width would wrap the row.
  // The frame is then shrunk mid-row. The column counter then sits past
  // the new last column and must act as that column, wrapping the row
  // right away.
  task automatic test_reset_size_and_resize();
    repeat (12) send_pixel(make_pixel(STYLE_UNIFORM, 0));
    write_reg(REG_IMAGE_WIDTH, 4);
    write_reg(REG_IMAGE_HEIGHT, 5);
    finish_frame(STYLE_UNIFORM);
  endtask

  // A 5 x 4 frame whose lanes are built to hit both saturation limits and
  // exact values: lane 0 is a 0/255 checkerboard (bright centres clip high,
  // dark centres clip low), lane 1 is flat 255, lane 2 flat 100 and lane 3 a
  // linear ramp, which the kernel returns unchanged.
  task automatic test_saturation();
    pix_t px;
    int   r, c;
    set_frame(5, 4, 4);
    for (r = 0; r < 4; r++) begin
      for (c = 0; c < 5; c++) begin
        px[0] = ((r + c) % 2 == 1) ? 8'd255 : 8'd0;
        px[1] = 8'd255;
        px[2] = 8'd100;
        px[3] = 8'((r * 5 + c) * 12);
        send_pixel(px);
      end
    end
  endtask

  // Every lane count, plus zero (acts as one) and seven (acts as four). Lanes
  // at or above the count must read back as zero. A write to the unmapped
  // index in between must leave the frame untouched.
  task automatic test_lane_counts();
    int counts [6];
    int i;
    counts = '{1, 2, 3, 4, 0, 7};
    set_frame(3, 3, 4);
    for (i = 0; i < 6; i++) begin
      write_reg(REG_CHANNEL_COUNT, counts[i]);
      if (i == 3) write_reg(REG_UNMAPPED, 12'hFFF);
      finish_frame(STYLE_UNIFORM);
    end
  endtask

  // Frame sizes at and beyond the limits. Too-small sizes clamp to 3. A frame
  // of width 4095 takes a dozen pixels of its first row and then narrows to
  // three columns mid-row; a frame of height 4095 takes three rows and then
  // shortens to three rows, so that its row counter sits past the new last
  // row. The whole test runs with no idling on either side.
  task automatic test_size_limits();
    no_idle = 1'b1;
    set_frame(0, 0, 4);
    finish_frame(STYLE_EXTREME);
    set_frame(2, 2, 4);
    finish_frame(STYLE_UNIFORM);
    set_frame(4095, 3, 4);
    repeat (12) send_pixel(make_pixel(STYLE_UNIFORM, 0));
    write_reg(REG_IMAGE_WIDTH, 3);
    finish_frame(STYLE_UNIFORM);
    set_frame(3, 4095, 4);
    repeat (9) send_pixel(make_pixel(STYLE_SMOOTH, 128));
    write_reg(REG_IMAGE_HEIGHT, 3);
    finish_frame(STYLE_SMOOTH);
    drain_block();
    no_idle = 1'b0;
  endtask

  function automatic int pick_width();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 2);
    return $urandom_range(3, 10);
  endfunction

  function automatic int pick_height();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 2);
    return $urandom_range(3, 6);
  endfunction

  // Small random frames with random lane counts and pixel styles. About one
  // phase in four is cut short and resized while in flight.
  task automatic test_random_frames();
    int           start;
    pixel_style_e style;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      set_frame(pick_width(), pick_height(), $urandom_range(0, 7));
      style = pixel_style_e'($urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 20)) send_pixel(make_pixel(style, $urandom_range(0, 255)));
        write_reg(REG_IMAGE_WIDTH, pick_width());
        write_reg(REG_IMAGE_HEIGHT, pick_height());
      end
      finish_frame(style);
    end
  endtask

  initial begin
    int i;
    for (i = 0; i < MAX_WIDTH; i++) begin
      line_above[i] = '0;
      line_above2[i] = '0;
    end
    for (i = 0; i < 6; i++) win_px[i] = '0;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_size_and_resize();
    test_saturation();
    test_lane_counts();
    test_size_limits();
    test_random_frames();

    drain_block();
    if (err_count == 0) begin
      $display("[laplacian_sharpen_3x3] OK");
    end else begin
      $display("[laplacian_sharpen_3x3] ERROR");
    end
    $finish;
  end

endmodule
